@@ rtl/gcb_pkg.sv @@
// ----------------------------------------------------------------------------
// gcb_pkg
// Shared types for the grapheme cluster boundary detector: break classes,
// Indic conjunct classes, conjunct tracking phase and the classified item.
// ----------------------------------------------------------------------------
`default_nettype none

package gcb_pkg;

    // grapheme break class codes
    typedef enum logic [3:0] {
        CLS_OTHER       = 4'd0,
        CLS_CR          = 4'd1,
        CLS_LF          = 4'd2,
        CLS_CONTROL     = 4'd3,
        CLS_EXTEND      = 4'd4,
        CLS_ZWJ         = 4'd5,
        CLS_RI          = 4'd6,
        CLS_PREPEND     = 4'd7,
        CLS_SPACINGMARK = 4'd8,
        CLS_L           = 4'd9,
        CLS_V           = 4'd10,
        CLS_T           = 4'd11,
        CLS_LV          = 4'd12,
        CLS_LVT         = 4'd13,
        CLS_PICT        = 4'd14
    } t_gclass;

    // indic conjunct class codes
    typedef enum logic [1:0] {
        CONJ_NONE      = 2'd0,
        CONJ_CONSONANT = 2'd1,
        CONJ_LINKER    = 2'd2,
        CONJ_EXTEND    = 2'd3
    } t_conj;

    // conjunct join tracking phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_CONS   = 2'd1,
        PH_LINKED = 2'd2
    } t_phase;

    // classified code point passed from front to back
    typedef struct packed {
        t_gclass cls;
        t_conj   conj;
        logic    sot;
        logic    cur_ctl;
        logic    cur_pict;
        logic    cur_ri;
    } t_item;

    localparam int unsigned QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

@@ rtl/gcb_if.sv @@
// ----------------------------------------------------------------------------
// gcb_if
// Valid/ready channels of the boundary detector: classified code points in,
// boundary flags out.
// ----------------------------------------------------------------------------
`default_nettype none

interface gcb_cp_if;
    logic       valid;
    logic       ready;
    logic [3:0] break_class;
    logic [1:0] conjunct_class;
    logic       start_of_text;

    modport source (output valid, output break_class, output conjunct_class,
                    output start_of_text, input ready);
    modport sink   (input valid, input break_class, input conjunct_class,
                    input start_of_text, output ready);
endinterface

interface gcb_brk_if;
    logic valid;
    logic ready;
    logic boundary_before;

    modport source (output valid, output boundary_before, input ready);
    modport sink   (input valid, input boundary_before, output ready);
endinterface

`default_nettype wire

@@ rtl/gcb_front.sv @@
// ----------------------------------------------------------------------------
// gcb_front
// Accepts code point requests, folds out-of-range classes to other and
// predecodes the current-item flags into one registered item.
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_front import gcb_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gcb_cp_if.sink     i_cp,
    output logic       o_valid,
    input  logic       i_ready,
    output t_item      o_item
);

    logic    r_valid;
    t_item   r_item;
    t_item   n_item;
    t_gclass cls;
    logic    take;

    // stage is free when empty or draining this cycle
    assign i_cp.ready = !r_valid || i_ready;
    assign take       = i_cp.valid && i_cp.ready;

    // classify: unused class code reads as other
    always_comb begin
        if (i_cp.break_class > CLS_PICT) begin
            cls = CLS_OTHER;
        end else begin
            cls = t_gclass'(i_cp.break_class);
        end
        n_item.cls      = cls;
        n_item.conj     = t_conj'(i_cp.conjunct_class);
        n_item.sot      = i_cp.start_of_text;
        n_item.cur_ctl  = (cls == CLS_CR) || (cls == CLS_LF) || (cls == CLS_CONTROL);
        n_item.cur_pict = (cls == CLS_PICT);
        n_item.cur_ri   = (cls == CLS_RI);
    end

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

@@ rtl/gcb_queue.sv @@
// ----------------------------------------------------------------------------
// gcb_queue
// Two-entry queue between classification and decision so that each side
// stalls on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_queue import gcb_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_item i_item,
    output logic  o_valid,
    input  logic  i_ready,
    output t_item o_item
);

    localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_item              r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               push;
    logic               pop;

    assign o_ready = (r_count != CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_item  = r_mem[r_rd_ptr];

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

`default_nettype wire

@@ rtl/gcb_back.sv @@
// ----------------------------------------------------------------------------
// gcb_back
// Holds the cluster state and decides one boundary per cycle unless o_brk
// stalls: pair table, conjunct join, emoji ZWJ join and regional indicator pairing.
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_back import gcb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_item     i_item,
    gcb_brk_if.source o_brk
);

    // pair table: 1 means a break between a and b
    function automatic logic pair_breaks(input t_gclass a, input t_gclass b);
        logic a_ctl;
        logic b_ctl;
        logic brk;
        a_ctl = (a == CLS_CR) || (a == CLS_LF) || (a == CLS_CONTROL);
        b_ctl = (b == CLS_CR) || (b == CLS_LF) || (b == CLS_CONTROL);
        if (a == CLS_CR && b == CLS_LF) begin
            brk = 1'b0;
        end else if (a_ctl || b_ctl) begin
            brk = 1'b1;
        end else if (a == CLS_L && (b inside {CLS_L, CLS_V, CLS_LV, CLS_LVT})) begin
            brk = 1'b0;
        end else if ((a inside {CLS_LV, CLS_V}) && (b inside {CLS_V, CLS_T})) begin
            brk = 1'b0;
        end else if ((a inside {CLS_LVT, CLS_T}) && b == CLS_T) begin
            brk = 1'b0;
        end else if (b inside {CLS_EXTEND, CLS_ZWJ, CLS_SPACINGMARK}) begin
            brk = 1'b0;
        end else if (a == CLS_PREPEND) begin
            brk = 1'b0;
        end else begin
            brk = 1'b1;
        end
        return brk;
    endfunction

    t_gclass r_prior;
    logic    r_pict_start;
    logic    r_ri_odd;
    t_phase  r_phase;
    logic    r_out_valid;
    logic    r_out_brk;

    t_gclass n_prior;
    logic    n_pict_start;
    logic    n_ri_odd;
    t_phase  n_phase;
    logic    brk;
    logic    prev_ctl;
    t_phase  ph;
    logic    take;

    assign o_ready = !r_out_valid || o_brk.ready;
    assign take    = i_valid && o_ready;
    assign prev_ctl = (r_prior == CLS_CR) || (r_prior == CLS_LF) || (r_prior == CLS_CONTROL);

    // boundary decision
    always_comb begin
        ph = r_phase;
        if (i_item.sot) begin
            brk = 1'b1;
            ph  = PH_IDLE;
        end else if (r_phase == PH_LINKED && i_item.conj == CONJ_CONSONANT &&
                     !prev_ctl && !i_item.cur_ctl) begin
            brk = 1'b0;
        end else if (r_pict_start && r_prior == CLS_ZWJ && i_item.cur_pict) begin
            brk = 1'b0;
        end else if (r_ri_odd && r_prior == CLS_RI && i_item.cur_ri) begin
            brk = 1'b0;
        end else begin
            brk = pair_breaks(r_prior, i_item.cls);
        end
    end

    // state update
    always_comb begin
        n_prior      = i_item.cls;
        n_pict_start = r_pict_start;
        n_ri_odd     = r_ri_odd;
        if (brk) begin
            n_pict_start = i_item.cur_pict;
            n_ri_odd     = i_item.cur_ri;
        end else if (i_item.cur_ri) begin
            n_ri_odd     = !r_ri_odd;
        end
        case (i_item.conj)
            CONJ_CONSONANT: n_phase = PH_CONS;
            CONJ_LINKER:    n_phase = (ph != PH_IDLE) ? PH_LINKED : PH_IDLE;
            CONJ_EXTEND:    n_phase = ph;
            default:        n_phase = PH_IDLE;
        endcase
    end

    // cluster state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior      <= CLS_OTHER;
            r_pict_start <= 1'b0;
            r_ri_odd     <= 1'b0;
            r_phase      <= PH_IDLE;
        end else if (take) begin
            r_prior      <= n_prior;
            r_pict_start <= n_pict_start;
            r_ri_odd     <= n_ri_odd;
            r_phase      <= n_phase;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (o_brk.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out_brk <= brk;
        end
    end

    assign o_brk.valid           = r_out_valid;
    assign o_brk.boundary_before = r_out_brk;

endmodule

`default_nettype wire

@@ rtl/grapheme_cluster_boundary.sv @@
// ----------------------------------------------------------------------------
// grapheme_cluster_boundary
// Extended grapheme cluster boundary detector over classified code points.
// ----------------------------------------------------------------------------
// i_cp carries one classified code point per request (break class, Indic
// conjunct class, start-of-text flag); o_brk returns one boundary_before
// flag per request, in order.
// A request passes the classify register, a queue entry and the
// decision/output register before its result is valid on o_brk.
// Throughput: one code point per cycle while o_brk takes results; the cluster
// state update is a loop closed through the decision stage registers.
// A two-entry queue sits between the classify stage and the decision stage,
// and the result has its own output register, so a new request is taken
// while a finished result waits.
// When o_brk stalls, results hold and the queue fills; i_cp.ready drops only
// once the output register, queue and classify stage are all full.
// Reset (synchronous, active low) empties every stage and clears the cluster
// state: prior class other, no pictographic start, even RI parity, conjunct
// tracking idle.
// ----------------------------------------------------------------------------
`default_nettype none

module grapheme_cluster_boundary import gcb_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gcb_cp_if.sink    i_cp,
    gcb_brk_if.source o_brk
);

    logic  front_valid;
    logic  front_ready;
    t_item front_item;
    logic  queue_valid;
    logic  queue_ready;
    t_item queue_item;

    // classify stage
    gcb_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cp    (i_cp),
        .o_valid (front_valid),
        .i_ready (front_ready),
        .o_item  (front_item)
    );

    // decoupling queue
    gcb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (front_ready),
        .i_item  (front_item),
        .o_valid (queue_valid),
        .i_ready (queue_ready),
        .o_item  (queue_item)
    );

    // decision stage
    gcb_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (queue_valid),
        .o_ready (queue_ready),
        .i_item  (queue_item),
        .o_brk   (o_brk)
    );

endmodule

`default_nettype wire

@@ rtl/gcb_checker.sv @@
// ----------------------------------------------------------------------------
// gcb_checker
// Port-level checks of the boundary detector: request/result balance,
// reset behavior and result hold under stall.
// ----------------------------------------------------------------------------
`default_nettype none

module gcb_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_brk
);

    logic [2:0] r_inflight;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    // requests accepted but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= r_inflight + {2'b00, in_acc} - {2'b00, out_acc};
        end
    end

    // no result right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // every result belongs to an accepted request
    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_inflight != 3'd0)
        else $error("result without an outstanding request");

    // storage never holds more than four requests
    a_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd4)
        else $error("more requests in flight than the pipeline holds");

    // an empty block always takes a request
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight == 3'd0 |-> i_in_ready)
        else $error("not ready while empty");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_brk))
        else $error("stalled result changed");

endmodule

bind grapheme_cluster_boundary gcb_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cp.valid),
    .i_in_ready  (i_cp.ready),
    .i_out_valid (o_brk.valid),
    .i_out_ready (o_brk.ready),
    .i_out_brk   (o_brk.boundary_before)
);

`default_nettype wire

@@ bench/tb_grapheme_cluster_boundary.sv @@
// ----------------------------------------------------------------------------
// tb_grapheme_cluster_boundary
// Self-checking bench for the grapheme cluster boundary detector. Classified
// code points go in on the request channel; a model of the cluster state
// (pair table, RI parity, emoji ZWJ join, Indic conjunct join) predicts
// every boundary flag, and each flag that comes back is compared in order.
// Directed items come first, then random noise, well-formed text runs, and
// phases at full rate and under heavy output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_grapheme_cluster_boundary;
    timeunit 1ns;
    timeprecision 1ps;
    import gcb_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int CYCLE_LIMIT  = 400000;

    // class code that lies outside the defined range
    localparam logic [3:0] CLS_UNASSIGNED = 4'd15;

    // output stall pattern, one bit per cycle
    localparam logic [15:0] STALL_PATTERN = 16'b1101_0011_1000_1110;

    typedef enum int {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_PATTERN,
        SINK_HEAVY
    } t_sink_mode;

    typedef enum int {
        RUN_EMOJI,
        RUN_RI,
        RUN_CONJUNCT,
        RUN_HANGUL,
        RUN_NEWLINE,
        RUN_PREPEND,
        RUN_NEW_TEXT
    } t_run_kind;

    typedef struct {
        logic [3:0] cls;
        logic [1:0] conj;
        bit         sot;
    } t_cp_req;

    bit clk = 1'b0;
    bit rst_n = 1'b0;

    gcb_cp_if  cp_if();
    gcb_brk_if brk_if();

    grapheme_cluster_boundary i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_cp    (cp_if.sink),
        .o_brk   (brk_if.source)
    );

    // clock
    always #(CLK_PERIOD / 2) clk = ~clk;

    // cluster state as the bench expects it
    logic [3:0] cl_prior_class;
    bit         cl_starts_pict;
    bit         cl_ri_odd;
    t_phase     cl_phase;

    bit         boundary_expected_q[$];
    bit         expected_flag;
    int         sent_count;
    int         result_count;
    int         boundary_count;
    int         fail_count;
    int         cycle_count;
    int         burst_left;
    int         gap_max;
    t_sink_mode sink_mode;

    function automatic bit is_control_class(logic [3:0] c);
        return c == CLS_CR || c == CLS_LF || c == CLS_CONTROL;
    endfunction

    // fixed pair table: 1 means the pair is split
    function automatic bit pair_splits(logic [3:0] a, logic [3:0] b);
        if (a == CLS_CR && b == CLS_LF) return 1'b0;
        if (is_control_class(a) || is_control_class(b)) return 1'b1;
        if (a == CLS_L && (b == CLS_L || b == CLS_V || b == CLS_LV || b == CLS_LVT))
            return 1'b0;
        if ((a == CLS_LV || a == CLS_V) && (b == CLS_V || b == CLS_T)) return 1'b0;
        if ((a == CLS_LVT || a == CLS_T) && b == CLS_T) return 1'b0;
        if (b == CLS_EXTEND || b == CLS_ZWJ || b == CLS_SPACINGMARK) return 1'b0;
        if (a == CLS_PREPEND) return 1'b0;
        return 1'b1;
    endfunction

    // boundary decision for one code point, advancing the cluster state
    function automatic bit predict_boundary(logic [3:0] cls_in, logic [1:0] conj, bit sot);
        logic [3:0] cur;
        logic [3:0] prev;
        t_phase     ph;
        bit         brk;
        cur  = (cls_in > CLS_PICT) ? CLS_OTHER : cls_in;
        prev = cl_prior_class;
        ph   = cl_phase;
        if (sot) begin
            brk = 1'b1;
            ph  = PH_IDLE;
        end else if (ph == PH_LINKED && conj == CONJ_CONSONANT &&
                     !is_control_class(prev) && !is_control_class(cur)) begin
            brk = 1'b0;
        end else if (cl_starts_pict && prev == CLS_ZWJ && cur == CLS_PICT) begin
            brk = 1'b0;
        end else if (cl_ri_odd && prev == CLS_RI && cur == CLS_RI) begin
            brk = 1'b0;
        end else begin
            brk = pair_splits(prev, cur);
        end
        // cluster tracking
        if (brk) begin
            cl_starts_pict = (cur == CLS_PICT);
            cl_ri_odd      = (cur == CLS_RI);
        end else if (cur == CLS_RI) begin
            cl_ri_odd = !cl_ri_odd;
        end
        cl_prior_class = cur;
        // conjunct phase follows conjunct classes and start of text only
        case (conj)
            CONJ_CONSONANT: cl_phase = PH_CONS;
            CONJ_LINKER: begin
                if (ph != PH_IDLE) cl_phase = PH_LINKED;
                else cl_phase = PH_IDLE;
            end
            CONJ_EXTEND: cl_phase = ph;
            default: cl_phase = PH_IDLE;
        endcase
        return brk;
    endfunction

    function automatic t_cp_req make_req(logic [3:0] cls, logic [1:0] conj, bit sot);
        t_cp_req r;
        r.cls  = cls;
        r.conj = conj;
        r.sot  = sot;
        return r;
    endfunction

    // send one code point, idling between bursts
    task automatic send_code_point(logic [3:0] cls, logic [1:0] conj, bit sot);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, gap_max);
            if (gap > 0) begin
                cp_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        cp_if.valid          <= 1'b1;
        cp_if.break_class    <= cls;
        cp_if.conjunct_class <= conj;
        cp_if.start_of_text  <= sot;
        do @(posedge clk); while (!cp_if.ready);
        boundary_expected_q.push_back(predict_boundary(cls, conj, sot));
        sent_count++;
    endtask

    function automatic logic [1:0] random_conj();
        if ($urandom_range(0, 9) < 7) return CONJ_NONE;
        return 2'($urandom_range(0, 3));
    endfunction

    // one well-formed text run with random content, sometimes broken
    task automatic send_text_run();
        t_cp_req run[$];
        int      n;
        int      k;
        int      link_at;
        case ($urandom_range(RUN_EMOJI, RUN_NEW_TEXT))
            RUN_EMOJI: begin
                run.push_back(make_req(CLS_PICT, random_conj(), 1'b0));
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    k = $urandom_range(0, 2);
                    repeat (k) run.push_back(make_req(CLS_EXTEND, random_conj(), 1'b0));
                    run.push_back(make_req(CLS_ZWJ, random_conj(), 1'b0));
                    run.push_back(make_req(CLS_PICT, random_conj(), 1'b0));
                end
            end
            RUN_RI: begin
                n = $urandom_range(1, 6);
                repeat (n) run.push_back(make_req(CLS_RI, random_conj(), 1'b0));
            end
            RUN_CONJUNCT: begin
                run.push_back(make_req(CLS_OTHER, CONJ_CONSONANT, 1'b0));
                n = $urandom_range(1, 3);
                for (int i = 0; i < n; i++) begin
                    k = $urandom_range(1, 3);
                    link_at = $urandom_range(0, k - 1);
                    for (int m = 0; m < k; m++) begin
                        run.push_back(make_req($urandom_range(0, 3) == 0 ? CLS_ZWJ : CLS_EXTEND,
                                               (m == link_at || $urandom_range(0, 1)) ?
                                               CONJ_LINKER : CONJ_EXTEND, 1'b0));
                    end
                    run.push_back(make_req($urandom_range(0, 1) ? CLS_OTHER : CLS_LV,
                                           CONJ_CONSONANT, 1'b0));
                end
            end
            RUN_HANGUL: begin
                n = $urandom_range(0, 2);
                repeat (n) run.push_back(make_req(CLS_L, random_conj(), 1'b0));
                case ($urandom_range(0, 2))
                    0: run.push_back(make_req(CLS_V, random_conj(), 1'b0));
                    1: run.push_back(make_req(CLS_LV, random_conj(), 1'b0));
                    default: run.push_back(make_req(CLS_LVT, random_conj(), 1'b0));
                endcase
                n = $urandom_range(0, 3);
                repeat (n) run.push_back(make_req($urandom_range(0, 1) ? CLS_V : CLS_T,
                                                  random_conj(), 1'b0));
            end
            RUN_NEWLINE: begin
                if ($urandom_range(0, 1)) run.push_back(make_req(CLS_CR, random_conj(), 1'b0));
                run.push_back(make_req($urandom_range(0, 1) ? CLS_LF : CLS_CONTROL,
                                       random_conj(), 1'b0));
            end
            RUN_PREPEND: begin
                n = $urandom_range(1, 2);
                repeat (n) run.push_back(make_req(CLS_PREPEND, random_conj(), 1'b0));
                run.push_back(make_req(4'($urandom_range(0, 15)), random_conj(), 1'b0));
                n = $urandom_range(0, 2);
                repeat (n) run.push_back(make_req($urandom_range(0, 1) ?
                                                  CLS_SPACINGMARK : CLS_EXTEND,
                                                  random_conj(), 1'b0));
            end
            default: begin
                run.push_back(make_req(4'($urandom_range(0, 15)), random_conj(), 1'b1));
            end
        endcase
        // broken run: one member replaced by noise
        if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(0, run.size() - 1);
            run[k] = make_req(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                              $urandom_range(0, 7) == 0);
        end
        foreach (run[i]) send_code_point(run[i].cls, run[i].conj, run[i].sot);
    endtask

    task automatic send_noise_item();
        send_code_point(4'($urandom_range(0, 15)), 2'($urandom_range(0, 3)),
                        $urandom_range(0, 49) == 0);
    endtask

    // directed: pair table, specials, RI, emoji and conjunct joins
    task automatic test_directed_rules();
        gap_max   = 3;
        sink_mode <= SINK_RANDOM;
        send_code_point(CLS_EXTEND, CONJ_NONE, 1'b0);
        send_code_point(CLS_OTHER, CONJ_NONE, 1'b0);
        send_code_point(CLS_CR, CONJ_NONE, 1'b1);
        send_code_point(CLS_LF, CONJ_NONE, 1'b0);
        send_code_point(CLS_CONTROL, CONJ_NONE, 1'b0);
        send_code_point(CLS_L, CONJ_NONE, 1'b0);
        send_code_point(CLS_L, CONJ_NONE, 1'b0);
        send_code_point(CLS_V, CONJ_NONE, 1'b0);
        send_code_point(CLS_LV, CONJ_NONE, 1'b0);
        send_code_point(CLS_T, CONJ_NONE, 1'b0);
        send_code_point(CLS_LVT, CONJ_NONE, 1'b0);
        send_code_point(CLS_T, CONJ_NONE, 1'b0);
        send_code_point(CLS_PREPEND, CONJ_NONE, 1'b0);
        send_code_point(CLS_UNASSIGNED, CONJ_NONE, 1'b0);
        send_code_point(CLS_SPACINGMARK, CONJ_NONE, 1'b0);
        send_code_point(CLS_RI, CONJ_NONE, 1'b0);
        send_code_point(CLS_RI, CONJ_NONE, 1'b0);
        send_code_point(CLS_RI, CONJ_NONE, 1'b0);
        send_code_point(CLS_PICT, CONJ_NONE, 1'b0);
        send_code_point(CLS_EXTEND, CONJ_NONE, 1'b0);
        send_code_point(CLS_ZWJ, CONJ_NONE, 1'b0);
        send_code_point(CLS_PICT, CONJ_NONE, 1'b0);
        // zwj before pictographic in a cluster that did not start pictographic
        send_code_point(CLS_OTHER, CONJ_CONSONANT, 1'b0);
        send_code_point(CLS_ZWJ, CONJ_LINKER, 1'b0);
        send_code_point(CLS_PICT, CONJ_CONSONANT, 1'b0);
        // linker then a consonant that is a control class
        send_code_point(CLS_EXTEND, CONJ_LINKER, 1'b0);
        send_code_point(CLS_CR, CONJ_CONSONANT, 1'b0);
    endtask

    task automatic test_random_noise(int count);
        int stop_at;
        gap_max   = 6;
        sink_mode <= SINK_RANDOM;
        stop_at   = sent_count + count;
        while (sent_count < stop_at) send_noise_item();
    endtask

    task automatic test_text_runs(int count);
        int stop_at;
        gap_max   = 5;
        sink_mode <= SINK_PATTERN;
        stop_at   = sent_count + count;
        while (sent_count < stop_at) begin
            if ($urandom_range(0, 4) == 0) send_noise_item();
            else send_text_run();
        end
    endtask

    task automatic test_full_rate(int count);
        int stop_at;
        gap_max   = 0;
        sink_mode <= SINK_ALWAYS;
        stop_at   = sent_count + count;
        while (sent_count < stop_at) begin
            if ($urandom_range(0, 4) == 0) send_noise_item();
            else send_text_run();
        end
    endtask

    task automatic test_heavy_backpressure(int count);
        int stop_at;
        gap_max   = 2;
        sink_mode <= SINK_HEAVY;
        stop_at   = sent_count + count;
        while (sent_count < stop_at) begin
            if ($urandom_range(0, 3) == 0) send_noise_item();
            else send_text_run();
        end
    endtask

    // result check and output stalls
    always @(posedge clk) begin
        if (rst_n && brk_if.valid && brk_if.ready) begin
            result_count <= result_count + 1;
            if (brk_if.boundary_before) boundary_count <= boundary_count + 1;
            if (boundary_expected_q.size() == 0) begin
                $error("unexpected result: boundary_before=%0b", brk_if.boundary_before);
                fail_count <= fail_count + 1;
            end else begin
                expected_flag = boundary_expected_q.pop_front();
                if (brk_if.boundary_before !== expected_flag) begin
                    $error("boundary_before mismatch: expected %0b, actual %0b",
                           expected_flag, brk_if.boundary_before);
                    fail_count <= fail_count + 1;
                end
            end
        end
        case (sink_mode)
            SINK_ALWAYS:  brk_if.ready <= 1'b1;
            SINK_RANDOM:  brk_if.ready <= ($urandom_range(0, 99) >= 30);
            SINK_PATTERN: brk_if.ready <= STALL_PATTERN[cycle_count % 16];
            default:      brk_if.ready <= ($urandom_range(0, 99) < 20);
        endcase
    end

    // run limit
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, boundary_expected_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        cp_if.valid          = 1'b0;
        cp_if.break_class    = CLS_OTHER;
        cp_if.conjunct_class = CONJ_NONE;
        cp_if.start_of_text  = 1'b0;
        brk_if.ready         = 1'b0;
        sink_mode            = SINK_ALWAYS;
        cl_prior_class       = CLS_OTHER;
        cl_starts_pict       = 1'b0;
        cl_ri_odd            = 1'b0;
        cl_phase             = PH_IDLE;
        sent_count           = 0;
        result_count         = 0;
        boundary_count       = 0;
        fail_count           = 0;
        cycle_count          = 0;
        burst_left           = 0;
        gap_max              = 0;

        // reset
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_rules();
        test_random_noise(300);
        test_text_runs(500);
        test_full_rate(200);
        test_heavy_backpressure(200);
        cp_if.valid <= 1'b0;

        // drain
        while (boundary_expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("sent %0d classified code points, checked %0d boundary flags (%0d set)",
                 sent_count, result_count, boundary_count);
        $display("phases: directed rules, noise, text runs, full rate, heavy stalls");
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/gcb_pkg.sv
rtl/gcb_if.sv
rtl/gcb_front.sv
rtl/gcb_queue.sv
rtl/gcb_back.sv
rtl/grapheme_cluster_boundary.sv
rtl/gcb_checker.sv
bench/tb_grapheme_cluster_boundary.sv
